// File: rtl/core/icmp_probe_reply_classifier_defines.svh
// Assertion macros used by the classifier checker.
`ifndef ICMP_PROBE_REPLY_CLASSIFIER_DEFINES_SVH
`define ICMP_PROBE_REPLY_CLASSIFIER_DEFINES_SVH

// same-cycle implication
`define ICPR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ICPR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/icpr_pkg.sv
// Package: types and constants of the ICMP probe reply classifier.
package icpr_pkg;

	localparam int MAX_PACKET_BYTES_DEF = 512;

	localparam int DATA_W   = 8;
	localparam int SEQ_W    = 16;
	localparam int PORT_W   = 16;
	localparam int HLEN_W   = 6;
	localparam int VERD_W   = 2;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_PROBE_IDENT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_PORT   = 1'd1;

	localparam logic [PORT_W-1:0] IDENT_RESET = 16'h8000;
	localparam logic [PORT_W-1:0] BASE_RESET  = 16'(32768 + 666);

	localparam logic [DATA_W-1:0] TYPE_TIMXCEED = 8'd11;
	localparam logic [DATA_W-1:0] TYPE_UNREACH  = 8'd3;
	localparam logic [DATA_W-1:0] PROTO_UDP     = 8'd17;
	localparam int INNER_FIT = 12;

	localparam logic [VERD_W-1:0] VERDICT_NONE    = 2'd0;
	localparam logic [VERD_W-1:0] VERDICT_TIMXCEED = 2'd1;
	localparam logic [VERD_W-1:0] VERDICT_UNREACH = 2'd2;

	typedef struct packed {
		logic [VERD_W-1:0] verdict;
		logic [DATA_W-1:0] unreach_code;
	} icpr_result_t;

endpackage

// File: rtl/core/icmp_probe_reply_classifier.sv
// Top level: ICMP probe reply classifier with stream ports and config port.
// Pipeline: an accepted byte is registered in the input stage and captured when it
// steps on; the verdict is registered in the output register when the last byte steps.
// Throughput: one byte per cycle; non-last bytes keep flowing while a verdict
// waits, a last byte stalls until the output register is free.
// Reset: arst_n clears pipeline, capture state, and restores config defaults.
module icmp_probe_reply_classifier
	import icpr_pkg::*;
#(
	parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [23:0]          s_tdata,  // [7:0] data_byte, [23:8] probe_seq
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          m_tdata,  // [1:0] verdict, [9:2] unreach_code, rest 0
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [PORT_W-1:0]    cfg_wdata
);

	logic [PORT_W-1:0] probe_ident_q, base_port_q;
	logic              vld_s1, last_s1;
	logic [DATA_W-1:0] byte_s1;
	logic [SEQ_W-1:0]  seq_s1;
	logic              out_vld_q;
	icpr_result_t      out_q, res;
	logic              out_free, step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_ident_q <= IDENT_RESET;
			base_port_q   <= BASE_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_PROBE_IDENT: probe_ident_q <= cfg_wdata;
				REG_BASE_PORT:   base_port_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign out_free = !out_vld_q || m_tready;
	assign step     = vld_s1 && (!last_s1 || out_free);
	assign s_tready = !vld_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (s_tready)
			vld_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata[7:0];
			seq_s1  <= s_tdata[23:8];
			last_s1 <= s_tlast;
		end
	end

	icpr_capture #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_capture (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.data_byte   (byte_s1),
		.last_byte   (last_s1),
		.probe_seq   (seq_s1),
		.probe_ident (probe_ident_q),
		.base_port   (base_port_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (step && last_s1)
			out_vld_q <= 1'b1;
		else if (m_tready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step && last_s1)
			out_q <= res;
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {6'b0, out_q.unreach_code, out_q.verdict};

endmodule

// File: rtl/core/icpr_capture.sv
// Per-packet field capture and verdict logic.
module icpr_capture
	import icpr_pkg::*;
#(
	parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [DATA_W-1:0]   data_byte,
	input  logic                last_byte,
	input  logic [SEQ_W-1:0]    probe_seq,
	input  logic [PORT_W-1:0]   probe_ident,
	input  logic [PORT_W-1:0]   base_port,
	output icpr_result_t        res
);

	localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 1);
	localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

	logic [CNT_W-1:0]  cnt_q, cnt_n;
	logic [HLEN_W-1:0] oh_q, ih_q, oh_b, ih_b, oh_n, ih_n;
	logic [DATA_W-1:0] type_q, code_q, proto_q, type_b, code_b, proto_b;
	logic [DATA_W-1:0] type_n, code_n, proto_n;
	logic [PORT_W-1:0] src_q, dst_q, src_b, dst_b, src_n, dst_n;
	logic [SEQ_W-1:0]  seq_q, seq_n;
	logic              first, take;
	logic [CMP_W-1:0]  pos, oh_w, ih_w, up, len;
	logic [PORT_W-1:0] dst_exp;
	logic [VERD_W-1:0] v;

	always_comb begin
		first = (cnt_q == '0);
		take  = ({1'b0, cnt_q} < (CNT_W+1)'(MAX_PACKET_BYTES));
		pos   = CMP_W'(cnt_q);

		oh_b    = first ? '0 : oh_q;
		ih_b    = first ? '0 : ih_q;
		type_b  = first ? '0 : type_q;
		code_b  = first ? '0 : code_q;
		proto_b = first ? '0 : proto_q;
		src_b   = first ? '0 : src_q;
		dst_b   = first ? '0 : dst_q;
		seq_n   = first ? probe_seq : seq_q;

		oh_n = (take && first) ? {data_byte[3:0], 2'b00} : oh_b;
		oh_w = CMP_W'(oh_n);
		type_n  = (take && pos == oh_w) ? data_byte : type_b;
		code_n  = (take && pos == oh_w + CMP_W'(1)) ? data_byte : code_b;
		ih_n    = (take && pos == oh_w + CMP_W'(8)) ? {data_byte[3:0], 2'b00} : ih_b;
		proto_n = (take && pos == oh_w + CMP_W'(17)) ? data_byte : proto_b;
		ih_w = CMP_W'(ih_n);
		up   = oh_w + CMP_W'(8) + ih_w;

		src_n = src_b;
		dst_n = dst_b;
		if (take && pos == up)              src_n[15:8] = data_byte;
		if (take && pos == up + CMP_W'(1))  src_n[7:0]  = data_byte;
		if (take && pos == up + CMP_W'(2))  dst_n[15:8] = data_byte;
		if (take && pos == up + CMP_W'(3))  dst_n[7:0]  = data_byte;

		cnt_n = take ? cnt_q + CNT_W'(1) : cnt_q;
		len   = CMP_W'(cnt_n);

		dst_exp = base_port + seq_n;
		res = '{verdict: VERDICT_NONE, unreach_code: '0};
		if (type_n == TYPE_TIMXCEED && code_n == '0)
			v = VERDICT_TIMXCEED;
		else if (type_n == TYPE_UNREACH)
			v = VERDICT_UNREACH;
		else
			v = VERDICT_NONE;
		if (len >= oh_w + CMP_W'(8) && v != VERDICT_NONE &&
			ih_w + CMP_W'(INNER_FIT) <= len - oh_w &&
			proto_n == PROTO_UDP && src_n == probe_ident && dst_n == dst_exp) begin
			res.verdict = v;
			if (v == VERDICT_UNREACH)
				res.unreach_code = code_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			oh_q    <= '0;
			ih_q    <= '0;
			type_q  <= '0;
			code_q  <= '0;
			proto_q <= '0;
			src_q   <= '0;
			dst_q   <= '0;
			seq_q   <= '0;
		end else if (step) begin
			cnt_q   <= last_byte ? '0 : cnt_n;
			oh_q    <= oh_n;
			ih_q    <= ih_n;
			type_q  <= type_n;
			code_q  <= code_n;
			proto_q <= proto_n;
			src_q   <= src_n;
			dst_q   <= dst_n;
			seq_q   <= seq_n;
		end
	end

endmodule

// File: rtl/core/icpr_checker.sv
// Port-level checker for the classifier, bound to the top level.
`include "icmp_probe_reply_classifier_defines.svh"

module icpr_checker
	import icpr_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	`ICPR_ASSERT_NOW(a_verdict_legal, m_tvalid, m_tdata[1:0] <= VERDICT_UNREACH, "illegal verdict")
	`ICPR_ASSERT_NOW(a_code_zero, m_tvalid && m_tdata[1:0] != VERDICT_UNREACH, m_tdata[9:2] == 8'd0, "code set without unreachable")
	`ICPR_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[15:10] == 6'd0, "tdata padding not zero")
	`ICPR_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled item changed")

endmodule

bind icmp_probe_reply_classifier icpr_checker u_icpr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
